FILE: sv/sem_pkg.sv
// sem_pkg: shared types and constants of the Sobel edge magnitude core.
// Used by the front, queue, back and top modules of the core; no dependencies.
package sem_pkg;

  localparam int DEF_MAX_LINE_WIDTH = 2048;
  localparam int FW_W = 12;
  localparam int FH_W = 13;
  localparam int CFG_DW = 13;
  localparam int VW = 14;
  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;
  localparam logic OP_FLUSH = 1'b1;

  // window pixels except the center: 00 01 02 10 12 20 21 22
  typedef struct packed {
    logic [7:0][7:0] pix;
    logic            interior;
    logic            frame_end;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qwr_t;

endpackage

FILE: sv/sem_in_if.sv
// sem_in_if: input pixel channel of the Sobel edge magnitude core.
// Depends on nothing.
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel_intensity;
  modport source(output valid, opcode, pixel_intensity, input ready);
  modport sink(input valid, opcode, pixel_intensity, output ready);
endinterface

FILE: sv/sem_out_if.sv
// sem_out_if: result channel of the Sobel edge magnitude core.
// Depends on nothing.
interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;
  logic       frame_end;
  modport source(output valid, edge_value, frame_end, input ready);
  modport sink(input valid, edge_value, frame_end, output ready);
endinterface

FILE: sv/sem_ram.sv
// sem_ram: generic one-write one-read RAM with registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/sem_front.sv
// sem_front: position tracking, line stores, 3x3 window and classification.
// Depends on sem_pkg, sem_in_if and sem_ram.
module sem_front import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [FW_W-1:0] frame_width,
  input  logic [FH_W-1:0] frame_height,
  sem_in_if.sink          in_pix,
  output qwr_t            qwr_o,
  input  logic            q_full
);
  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam logic [VW-1:0] MAXV = VW'(MAX_LINE_WIDTH);
  localparam logic [VW-1:0] THREE = VW'(3);

  typedef enum logic [1:0] {F_IDLE = 2'b01, F_EXEC = 2'b10} fstate_t;

  fstate_t state_r, state_nxt;
  logic [AW-1:0] col_r, col_nxt, cq_r;
  logic [VW-1:0] row_r, row_nxt, rq_r;
  logic [7:0]    pix_r;
  logic [2:0][2:0][7:0] win_r, win_nxt;
  logic [7:0] up_rd, mid_rd;

  logic [VW-1:0] w_v, h_v, fw_e, fh_e, c1, r1, cx, cinc, orow, ocol;
  logic accept, noresult, interior, is_end, commit;

  assign fw_e = VW'(frame_width);
  assign fh_e = VW'(frame_height);
  assign w_v = (fw_e < THREE) ? THREE : ((fw_e > MAXV) ? MAXV : fw_e);
  assign h_v = (fh_e < THREE) ? THREE : fh_e;

  assign in_pix.ready = (state_r == F_IDLE);
  assign accept = in_pix.valid && in_pix.ready;

  always_comb begin
    c1 = VW'(col_r);
    r1 = row_r;
    if (c1 >= w_v) begin
      c1 = '0;
      r1 = r1 + VW'(1);
    end
    if (r1 > h_v + VW'(1)) begin
      r1 = h_v + VW'(1);
      c1 = '0;
    end
  end

  sem_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_up (
    .clk(clk), .we(commit), .waddr(cq_r), .wdata(mid_rd),
    .re(accept), .raddr(c1[AW-1:0]), .rdata(up_rd)
  );
  sem_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_mid (
    .clk(clk), .we(commit), .waddr(cq_r), .wdata(pix_r),
    .re(accept), .raddr(c1[AW-1:0]), .rdata(mid_rd)
  );

  always_comb begin
    cx = VW'(cq_r);
    noresult = (rq_r == '0) || (rq_r == VW'(1) && cx == '0);
    if (cx == '0) begin
      orow = rq_r - VW'(2);
      ocol = w_v - VW'(1);
    end else begin
      orow = rq_r - VW'(1);
      ocol = cx - VW'(1);
    end
    interior = (orow >= VW'(1)) && (orow + VW'(2) <= h_v) &&
               (ocol >= VW'(1)) && (ocol + VW'(2) <= w_v);
    is_end = !noresult && (rq_r == h_v + VW'(1)) && (cx == '0);
    commit = (state_r == F_EXEC) && (noresult || !q_full);
    cinc = cx + VW'(1);
    if (is_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cinc >= w_v) begin
      col_nxt = '0;
      row_nxt = rq_r + VW'(1);
    end else begin
      col_nxt = cinc[AW-1:0];
      row_nxt = rq_r;
    end
    win_nxt = win_r;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = up_rd;
    win_nxt[1][2] = mid_rd;
    win_nxt[2][2] = pix_r;
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_EXEC;
      F_EXEC:  if (commit) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  assign qwr_o.push = commit && !noresult;
  assign qwr_o.ent.pix = {win_nxt[2][2], win_nxt[2][1], win_nxt[2][0], win_nxt[1][2],
                          win_nxt[1][0], win_nxt[0][2], win_nxt[0][1], win_nxt[0][0]};
  assign qwr_o.ent.interior = interior;
  assign qwr_o.ent.frame_end = is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      win_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cq_r  <= c1[AW-1:0];
      rq_r  <= r1;
      pix_r <= (in_pix.opcode == OP_FLUSH) ? 8'd0 : in_pix.pixel_intensity;
    end
  end
endmodule

FILE: sv/sem_queue.sv
// sem_queue: two-entry queue between front and back.
// Depends on sem_pkg.
module sem_queue import sem_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  qwr_t  qwr_i,
  output logic  full,
  output logic  q_valid,
  output qent_t q_ent,
  input  logic  pop
);
  qent_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_pop;

  assign full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_ent = mem_r[rp_r];
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (qwr_i.push) begin
      mem_r[wp_r] <= qwr_i.ent;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (qwr_i.push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(qwr_i.push) - 2'(do_pop);
    end
  end
endmodule

FILE: sv/sem_back.sv
// sem_back: Sobel sums, squared magnitude and iterative integer root.
// Depends on sem_pkg and sem_out_if.
module sem_back import sem_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  qent_t   q_ent,
  output logic    pop,
  sem_out_if.source out_res
);
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001, B_GRAD = 5'b00010, B_SQR = 5'b00100,
    B_ROOT = 5'b01000, B_OUT = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic [7:0][7:0] pix_r;
  logic end_r;
  logic [9:0] ax_r, ay_r;
  logic [19:0] sx_r, sy_r;
  logic [15:0] v_r, res_r, bit_r;
  logic [7:0] edge_r;
  logic sqr_ph_r;

  logic signed [11:0] gx, gy;
  logic [22:0] fs;
  logic [16:0] t;

  assign pop = (state_r == B_IDLE) && q_valid;

  always_comb begin
    gx = (12'(pix_r[2]) + 12'({pix_r[4], 1'b0}) + 12'(pix_r[7]))
       - (12'(pix_r[0]) + 12'({pix_r[3], 1'b0}) + 12'(pix_r[5]));
    gy = (12'(pix_r[5]) + 12'({pix_r[6], 1'b0}) + 12'(pix_r[7]))
       - (12'(pix_r[0]) + 12'({pix_r[1], 1'b0}) + 12'(pix_r[2]));
    fs = (23'(sx_r) + 23'(sy_r)) << 2;
    t = 17'(res_r) + 17'(bit_r);
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = q_ent.interior ? B_GRAD : B_OUT;
      B_GRAD:  state_nxt = B_SQR;
      B_SQR:   if (sqr_ph_r) state_nxt = (fs >= 23'd65536) ? B_OUT : B_ROOT;
      B_ROOT:  if (bit_r == 16'd1) state_nxt = B_OUT;
      B_OUT:   if (out_res.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_res.valid = (state_r == B_OUT);
  assign out_res.edge_value = edge_r;
  assign out_res.frame_end = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    case (state_r)
      B_IDLE: begin
        pix_r    <= q_ent.pix;
        end_r    <= q_ent.frame_end;
        edge_r   <= 8'd0;
        sqr_ph_r <= 1'b0;
      end
      B_GRAD: begin
        ax_r <= gx[11] ? 10'(-gx) : 10'(gx);
        ay_r <= gy[11] ? 10'(-gy) : 10'(gy);
      end
      B_SQR: begin
        if (!sqr_ph_r) begin
          sx_r     <= ax_r * ax_r;
          sy_r     <= ay_r * ay_r;
          sqr_ph_r <= 1'b1;
        end else begin
          v_r    <= fs[15:0];
          res_r  <= 16'd0;
          bit_r  <= 16'h4000;
          edge_r <= 8'd255;
        end
      end
      B_ROOT: begin
        if (17'(v_r) >= t) begin
          v_r   <= v_r - t[15:0];
          res_r <= (res_r >> 1) + bit_r;
          if (bit_r == 16'd1) edge_r <= 8'(((res_r >> 1) + bit_r));
        end else begin
          res_r <= res_r >> 1;
          if (bit_r == 16'd1) edge_r <= 8'(res_r >> 1);
        end
        bit_r <= bit_r >> 2;
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end
endmodule

FILE: sv/sobel_edge_magnitude_core.sv
// Sobel 3x3 edge magnitude core: raster pixels in, min(255, floor(2*|grad|)) out.
// Per item the front reads the line stores, then updates window and stores once
// the queue has room. An interior result in the back goes through sums, squares,
// sum, eight root steps and output; one that saturates before the root skips it,
// and a border result goes straight to output. The back's root iterations set the
// sustained rate, the two-entry queue lets the front run ahead. Results trail
// input by one row and one column; frame_width+1 flush beats push out the end of
// the image. Line stores hold no reset content and need no clearing pass.
module sobel_edge_magnitude_core import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  sem_in_if.sink            in_pix,
  sem_out_if.source         out_res
);
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  qwr_t  qwr;
  logic  q_full, q_valid, pop;
  qent_t q_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  sem_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .frame_width(fw_r), .frame_height(fh_r),
    .in_pix(in_pix), .qwr_o(qwr), .q_full(q_full)
  );

  sem_queue u_queue (
    .clk(clk), .rst_n(rst_n), .qwr_i(qwr), .full(q_full),
    .q_valid(q_valid), .q_ent(q_ent), .pop(pop)
  );

  sem_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ent(q_ent),
    .pop(pop), .out_res(out_res)
  );
endmodule
